// ----- src/sqsd_pkg.sv -----
// ----------------------------------------------------------------------------
// sqsd_pkg - shared types and constants of the shortest-queue dispatcher
// Queue sizing, result event codes, controller states and the command
// bundle between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sqsd_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned NSRV        = 3;
  localparam int unsigned SRV_W       = 2;
  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned STORE_DEPTH = NSRV * QUEUE_DEPTH;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned ID_W        = 16;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned ENTRY_W     = ID_W + LEN_W;
  localparam int unsigned TIME_W      = 16;

  typedef logic [SRV_W-1:0] srv_t;

  typedef enum logic [2:0] {
    EV_JOINED   = 3'd0,
    EV_REJECTED = 3'd1,
    EV_STARTED  = 3'd2,
    EV_IDLE     = 3'd3,
    EV_SERVING  = 3'd4
  } ev_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRV0,
    ST_SRV1,
    ST_SRV2,
    ST_EMIT
  } state_e;

  typedef struct packed {
    ev_e               ev;
    srv_t              unit;
    logic [ID_W-1:0]   job;
    logic [TIME_W-1:0] fin;
  } res_t;

  typedef struct packed {
    logic arr_en;    // apply the arrival on the input port
    logic rd_en;     // read the head entry of rd_srv's queue
    srv_t rd_srv;
    logic upd_en;    // visit server upd_srv with the entry just read
    srv_t upd_srv;
    logic time_adv;  // advance the clock by one tick
    srv_t emit_idx;  // result slot shown on the output
  } cmd_t;

  // First store address of a server's queue region
  function automatic logic [ADDR_W-1:0] srv_base(input srv_t idx);
    logic [ADDR_W-1:0] base;
    case (idx)
      2'd0:    base = '0;
      2'd1:    base = ADDR_W'(QUEUE_DEPTH);
      default: base = ADDR_W'(2 * QUEUE_DEPTH);
    endcase
    return base;
  endfunction

endpackage

`default_nettype wire

// ----- src/sqsd_if.sv -----
// ----------------------------------------------------------------------------
// sqsd_in_if / sqsd_out_if - item channels of the dispatcher
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqsd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] customer_id;
  logic [7:0]  service_length;
  logic        last_arrival;

  modport source (output valid, kind, customer_id, service_length, last_arrival,
                  input ready);
  modport sink   (input valid, kind, customer_id, service_length, last_arrival,
                  output ready);
endinterface

interface sqsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [1:0]  unit;
  logic [15:0] job_id;
  logic [15:0] finish_time;
  logic        all_done;
  logic        last;

  modport source (output valid, event_res, unit, job_id, finish_time, all_done, last,
                  input ready);
  modport sink   (input valid, event_res, unit, job_id, finish_time, all_done, last,
                  output ready);
endinterface

`default_nettype wire

// ----- src/sqsd_ram.sv -----
// ----------------------------------------------------------------------------
// sqsd_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sqsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- src/sqsd_ctrl.sv -----
// ----------------------------------------------------------------------------
// sqsd_ctrl - dispatcher sequencer
// Accept an item, step the three server visits of a tick and hand out results.
// ----------------------------------------------------------------------------
`default_nettype none

module sqsd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_kind_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic               out_last_o,
  output sqsd_pkg::cmd_t     cmd_o
);
  import sqsd_pkg::*;

  state_e state_q, state_d;
  logic   tick_q, tick_d;
  srv_t   emit_idx_q, emit_idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tick_q     <= 1'b0;
      emit_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      tick_q     <= tick_d;
      emit_idx_q <= emit_idx_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    emit_idx_d   = emit_idx_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    out_last_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.emit_idx = emit_idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          emit_idx_d = '0;
          tick_d     = in_kind_i;
          if (in_kind_i) begin
            // fetch server 0's head entry at once
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_srv = srv_t'(0);
            state_d      = ST_SRV0;
          end else begin
            cmd_o.arr_en = 1'b1;
            state_d      = ST_EMIT;
          end
        end
      end
      ST_SRV0: begin
        cmd_o.upd_en  = 1'b1;
        cmd_o.upd_srv = srv_t'(0);
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_srv  = srv_t'(1);
        state_d       = ST_SRV1;
      end
      ST_SRV1: begin
        cmd_o.upd_en  = 1'b1;
        cmd_o.upd_srv = srv_t'(1);
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_srv  = srv_t'(2);
        state_d       = ST_SRV2;
      end
      ST_SRV2: begin
        cmd_o.upd_en   = 1'b1;
        cmd_o.upd_srv  = srv_t'(2);
        cmd_o.time_adv = 1'b1;
        emit_idx_d     = '0;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        out_last_o  = !tick_q || (emit_idx_q == srv_t'(NSRV - 1));
        if (out_ready_i) begin
          if (out_last_o) begin
            state_d = ST_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + srv_t'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_tick_starts_visits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_kind_i) |=> (state_q == ST_SRV0))
    else $error("tick not followed by server visits");

  a_arrival_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !tick_q) |-> (emit_idx_q == '0))
    else $error("arrival emitting more than one result");

  a_visits_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRV2) |=> (state_q == ST_EMIT && emit_idx_q == '0 && tick_q))
    else $error("tick visits not followed by emission from slot zero");

endmodule

`default_nettype wire

// ----- src/sqsd_dp.sv -----
// ----------------------------------------------------------------------------
// sqsd_dp - dispatcher datapath
// Queue pointers, server state, time, the queue store and the result slots.
// ----------------------------------------------------------------------------
`default_nettype none

module sqsd_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sqsd_pkg::cmd_t                cmd_i,
  input  wire logic [sqsd_pkg::ID_W-1:0]     customer_id_i,
  input  wire logic [sqsd_pkg::LEN_W-1:0]    service_length_i,
  input  wire logic                          last_arrival_i,
  output sqsd_pkg::res_t                     res_o,
  output logic                               all_done_o
);
  import sqsd_pkg::*;

  logic [TIME_W-1:0] time_q, time_d;
  logic              arr_fin_q, arr_fin_d;
  logic [SLOT_W-1:0] head_q  [NSRV];
  logic [SLOT_W-1:0] head_d  [NSRV];
  logic [CNT_W-1:0]  count_q [NSRV];
  logic [CNT_W-1:0]  count_d [NSRV];
  logic [NSRV-1:0]   busy_q, busy_d;
  logic [TIME_W-1:0] end_q   [NSRV];
  logic [TIME_W-1:0] end_d   [NSRV];
  logic [ID_W-1:0]   job_q   [NSRV];
  logic [ID_W-1:0]   job_d   [NSRV];
  res_t              res_q   [NSRV];
  res_t              res_d   [NSRV];

  logic [CNT_W:0]      load     [NSRV];
  logic [SLOT_W-1:0]   slot     [NSRV];
  logic [CNT_W:0]      slot_sum [NSRV];
  logic [NSRV-1:0]     full_vec;
  srv_t                sel;
  logic                full_sel;
  logic [LEN_W-1:0]    len_fix;
  logic [SLOT_W-1:0]   head_rd;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic                we;
  logic [ENTRY_W-1:0]  wdata, rdata;

  // Per-queue load, fullness and tail slot
  always_comb begin
    for (int i = 0; i < NSRV; i++) begin
      load[i]     = (CNT_W+1)'(count_q[i]) + (CNT_W+1)'(busy_q[i]);
      full_vec[i] = (count_q[i] == CNT_W'(QUEUE_DEPTH));
      slot_sum[i] = (CNT_W+1)'(head_q[i]) + (CNT_W+1)'(count_q[i]);
      if (slot_sum[i] >= (CNT_W+1)'(QUEUE_DEPTH)) begin
        slot[i] = SLOT_W'(slot_sum[i] - (CNT_W+1)'(QUEUE_DEPTH));
      end else begin
        slot[i] = SLOT_W'(slot_sum[i]);
      end
    end
  end

  // Shortest queue, ties to the lower index
  always_comb begin
    sel = srv_t'(0);
    if (load[0] > load[1]) begin
      sel = srv_t'(1);
    end
    if ((sel == srv_t'(1) ? load[1] : load[0]) > load[2]) begin
      sel = srv_t'(2);
    end
  end

  assign full_sel = full_vec[sel];
  assign len_fix  = (service_length_i == '0) ? LEN_W'(1) : service_length_i;
  assign we       = cmd_i.arr_en && !full_sel;
  assign waddr    = srv_base(sel) + ADDR_W'(slot[sel]);
  assign wdata    = {customer_id_i, len_fix};

  always_comb begin
    head_rd = '0;
    for (int i = 0; i < NSRV; i++) begin
      if (cmd_i.rd_srv == srv_t'(i)) begin
        head_rd = head_q[i];
      end
    end
  end

  assign raddr = srv_base(cmd_i.rd_srv) + ADDR_W'(head_rd);

  sqsd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    time_d    = time_q;
    arr_fin_d = arr_fin_q;
    head_d    = head_q;
    count_d   = count_q;
    busy_d    = busy_q;
    end_d     = end_q;
    job_d     = job_q;
    res_d     = res_q;

    if (cmd_i.arr_en) begin
      res_d[0] = '{ev:   full_sel ? EV_REJECTED : EV_JOINED,
                   unit: sel,
                   job:  customer_id_i,
                   fin:  '0};
      for (int i = 0; i < NSRV; i++) begin
        if (sel == srv_t'(i) && !full_sel) begin
          count_d[i] = count_q[i] + CNT_W'(1);
        end
      end
      if (last_arrival_i) begin
        arr_fin_d = 1'b1;
      end
    end

    if (cmd_i.upd_en) begin
      for (int i = 0; i < NSRV; i++) begin
        if (cmd_i.upd_srv == srv_t'(i)) begin
          if (!busy_q[i] || end_q[i] == time_q) begin
            if (count_q[i] != '0) begin
              // pop the head and start service
              head_d[i]  = (head_q[i] == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : head_q[i] + SLOT_W'(1);
              count_d[i] = count_q[i] - CNT_W'(1);
              job_d[i]   = rdata[ENTRY_W-1:LEN_W];
              end_d[i]   = time_q + TIME_W'(rdata[LEN_W-1:0]);
              busy_d[i]  = 1'b1;
              res_d[i]   = '{ev: EV_STARTED, unit: srv_t'(i),
                             job: rdata[ENTRY_W-1:LEN_W],
                             fin: time_q + TIME_W'(rdata[LEN_W-1:0])};
            end else begin
              busy_d[i] = 1'b0;
              res_d[i]  = '{ev: EV_IDLE, unit: srv_t'(i), job: job_q[i], fin: '0};
            end
          end else begin
            res_d[i] = '{ev: EV_SERVING, unit: srv_t'(i), job: job_q[i], fin: end_q[i]};
          end
        end
      end
    end

    if (cmd_i.time_adv) begin
      time_d = time_q + TIME_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q    <= '0;
      arr_fin_q <= 1'b0;
      head_q    <= '{default: '0};
      count_q   <= '{default: '0};
      busy_q    <= '0;
      end_q     <= '{default: '0};
      job_q     <= '{default: '0};
    end else begin
      time_q    <= time_d;
      arr_fin_q <= arr_fin_d;
      head_q    <= head_d;
      count_q   <= count_d;
      busy_q    <= busy_d;
      end_q     <= end_d;
      job_q     <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_comb begin
    res_o = res_q[0];
    for (int i = 0; i < NSRV; i++) begin
      if (cmd_i.emit_idx == srv_t'(i)) begin
        res_o = res_q[i];
      end
    end
  end

  assign all_done_o = arr_fin_q && (busy_q == '0) && (count_q[0] == '0)
                      && (count_q[1] == '0) && (count_q[2] == '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q[0] <= CNT_W'(QUEUE_DEPTH)) && (count_q[1] <= CNT_W'(QUEUE_DEPTH))
    && (count_q[2] <= CNT_W'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.time_adv |=> (time_q == $past(time_q) + TIME_W'(1)))
    else $error("time did not advance by one");

  a_arrival_vs_visit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.arr_en |-> (!cmd_i.upd_en && !cmd_i.time_adv))
    else $error("arrival overlaps a server visit");

endmodule

`default_nettype wire

// ----- src/shortest_queue_server_dispatch.sv -----
// ----------------------------------------------------------------------------
// shortest_queue_server_dispatch - join-shortest-queue dispatcher, 3 servers
// Arrivals join the least loaded queue; ticks visit each server in turn,
// starting queued jobs as servers free up, then advance time.
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                                              | items
//   ---------+-----+------------------------------------------------------+--------
//   in_i     | in  | kind, customer_id, service_length, last_arrival      | 1
//   out_o    | out | event_res, unit, job_id, finish_time, all_done, last | 1 or 3
//
// An arrival: the accept edge updates the queue and writes the store, then the
// result is shown. A tick: the accept edge, three server visits paced by the
// single read port of the queue store (one head read per server, registered),
// then three results. One item is in flight at a time; the input is not ready
// until every result of the previous item has been taken, and an output stall
// holds the current result.
// Reset is asynchronous, active low; the queue store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_queue_server_dispatch (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sqsd_in_if.sink    in_i,
  sqsd_out_if.source out_o
);
  import sqsd_pkg::*;

  cmd_t cmd;
  res_t res;
  logic all_done;

  // Sequencer: accepts items, steps the server visits, paces the results
  sqsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_last_o  (out_o.last),
    .cmd_o       (cmd)
  );

  // Queues, servers, time and the result slots
  sqsd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .customer_id_i    (in_i.customer_id),
    .service_length_i (in_i.service_length),
    .last_arrival_i   (in_i.last_arrival),
    .res_o            (res),
    .all_done_o       (all_done)
  );

  // all_done reflects the state after the whole item, so it is shared by
  // every result of that item
  assign out_o.event_res   = res.ev;
  assign out_o.unit        = res.unit;
  assign out_o.job_id      = res.job;
  assign out_o.finish_time = res.fin;
  assign out_o.all_done    = all_done;

endmodule

`default_nettype wire
